// ===== src/fts_pkg.sv =====
// Shared types and constants for the frame-time window statistics block.
// Used by fts_ctrl, fts_dp and frame_time_window_statistics; no dependencies.
package fts_pkg;

   localparam int WINDOW = 64;
   localparam int TIME_W = 24;
   localparam int RATE_W = 28;
   localparam int COUNT_W = 32;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W = TIME_W + $clog2(WINDOW);

   // Shared divider: the dividend must hold both the window sum and the rate numerator.
   localparam int DIV_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [DIV_W-1:0] RATE_NUMERATOR = DIV_W'(256000000);

   localparam int RSP_FIELDS_W = 3 * TIME_W + RATE_W + COUNT_W;
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_W - RSP_FIELDS_W;

   // Operation carried in the request tuser bit.
   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_CLEAR  = 1'b1
   } fts_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV_AVG,
      ST_AVG,
      ST_DIV_RATE,
      ST_RATE,
      ST_EMIT
   } fts_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic rd;
      logic update;
      logic div_step;
      logic take_avg;
      logic take_rate;
      logic load_out;
   } fts_cmd_type;

   typedef struct packed {
      logic div_last;
      logic avg_zero;
   } fts_sts_type;

endpackage

// ===== src/frame_time_window_statistics.sv =====
// A record transfer walks through a ring read, the window update and two serial
// divisions; the rate division is skipped when the mean is zero, and a clear goes
// straight to the result register. One record is taken at a time, through the shared
// bit-serial divider; a finished result waits in its own register while the next is taken.
// Reset is synchronous, active high: statistics return to their cleared values and
// no result is pending. Ring contents are not cleared; entries are read only once written.
module frame_time_window_statistics (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [fts_pkg::TIME_W-1:0] req_tdata,  // frame_time_us
   input  logic                       req_tuser,  // cmd: 0 record a frame, 1 clear
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // avg_frame_us, fps_q8, min_frame_us, max_frame_us, frames_seen, zero pad
   output logic [fts_pkg::RSP_W-1:0]  rsp_tdata
);
   import fts_pkg::*;

   // The controller and datapath talk only through these command and status groups.
   fts_cmd_type cmd;
   fts_sts_type sts;

   // The controller owns the handshakes and the result-valid flag; each record
   // walks through a ring read, the window update, the mean division and, when
   // the mean is nonzero, the rate division.
   fts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the sample ring, the running statistics and the
   // result register that carries the payload of each result transfer.
   fts_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_time (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule

// ===== src/fts_dp.sv =====
// Datapath of the frame-time window statistics block: sample ring, running
// statistics, a shared bit-serial divider and the result register. Depends on fts_pkg.
module fts_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  fts_pkg::fts_cmd_type       cmd,
   output fts_pkg::fts_sts_type       sts,
   input  logic [fts_pkg::TIME_W-1:0] req_time,
   output logic [fts_pkg::RSP_W-1:0]  rsp_data
);
   import fts_pkg::*;

   logic [TIME_W-1:0]  ring_mem [WINDOW];
   logic [TIME_W-1:0]  rd_data_ff;
   logic [TIME_W-1:0]  item_time_ff;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]  least_ff, greatest_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [TIME_W-1:0]  avg_ff;
   logic               full;

   logic [DIV_W-1:0]   num_ff, quo_ff;
   logic [TIME_W-1:0]  divisor_ff, rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [TIME_W:0]    rem_shift;
   logic [TIME_W+1:0]  diff;
   logic               fits;

   logic [RSP_W-1:0]   rsp_data_ff;

   // Window update: the oldest sample leaves the sum once the window is full.
   always_comb begin
      full    = (fill_ff == FILL_W'(WINDOW));
      sum_in  = sum_ff - (full ? SUM_W'(rd_data_ff) : '0) + SUM_W'(item_time_ff);
      fill_in = full ? fill_ff : fill_ff + FILL_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ring_mem[slot_ff] <= item_time_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= ring_mem[slot_ff];
      end
      if (cmd.capture) begin
         item_time_ff <= req_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         least_ff    <= '1;
         greatest_ff <= '0;
         total_ff    <= '0;
      end else if (cmd.update) begin
         slot_ff  <= slot_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         total_ff <= total_ff + COUNT_W'(1);
         if (item_time_ff < least_ff) begin
            least_ff <= item_time_ff;
         end
         if (item_time_ff > greatest_ff) begin
            greatest_ff <= item_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         avg_ff  <= '0;
         rate_ff <= '0;
      end else begin
         if (cmd.take_avg) begin
            avg_ff <= quo_ff[TIME_W-1:0];
         end
         if (cmd.take_rate) begin
            rate_ff <= quo_ff[RATE_W-1:0];
         end
      end
   end

   // Restoring divider, one quotient bit per cycle. The remainder stays below
   // the divisor, so it fits in the divisor's width between steps.
   always_comb begin
      rem_shift = {rem_ff, num_ff[DIV_W-1]};
      diff      = {1'b0, rem_shift} - {2'b00, divisor_ff};
      fits      = !diff[TIME_W+1];
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         num_ff     <= DIV_W'(sum_in);
         divisor_ff <= TIME_W'(fill_in);
         rem_ff     <= '0;
         cnt_ff     <= '0;
      end else if (cmd.take_avg) begin
         num_ff     <= RATE_NUMERATOR;
         divisor_ff <= quo_ff[TIME_W-1:0];
         rem_ff     <= '0;
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[DIV_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, total_ff, greatest_ff, least_ff, rate_ff, avg_ff};
      end
   end

   assign sts.div_last = (cnt_ff == CNT_W'(DIV_W - 1));
   assign sts.avg_zero = (quo_ff[TIME_W-1:0] == '0);
   assign rsp_data     = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill level exceeds window depth");
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (sum_ff == '0))
      else $error("empty window carries a nonzero sum");
`endif

endmodule

// ===== src/fts_ctrl.sv =====
// Controller of the frame-time window statistics block: sequences ring access,
// both divisions and the result register. Depends on fts_pkg.
module fts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output fts_pkg::fts_cmd_type cmd,
   input  fts_pkg::fts_sts_type sts
);
   import fts_pkg::*;

   fts_state_type state_ff, state_in;
   logic          rsp_valid_ff;
   logic          accept;
   logic          out_free;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = (req_tuser == OP_CLEAR) ? ST_EMIT : ST_READ;
         ST_READ:     state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DIV_AVG;
         ST_DIV_AVG:  if (sts.div_last) state_in = ST_AVG;
         ST_AVG:      state_in = sts.avg_zero ? ST_EMIT : ST_DIV_RATE;
         ST_DIV_RATE: if (sts.div_last) state_in = ST_RATE;
         ST_RATE:     state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // The ready output is high throughout idle, so a valid request there is a transfer.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.clear   = req_tvalid && (req_tuser == OP_CLEAR);
            cmd.capture = req_tvalid && (req_tuser == OP_RECORD);
         end
         ST_READ:     cmd.rd = 1'b1;
         ST_UPDATE:   cmd.update = 1'b1;
         ST_DIV_AVG:  cmd.div_step = 1'b1;
         ST_AVG:      cmd.take_avg = 1'b1;
         ST_DIV_RATE: cmd.div_step = 1'b1;
         ST_RATE:     cmd.take_rate = 1'b1;
         ST_EMIT:     cmd.load_out = out_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while still held");
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_CLEAR)) |-> ##2 rsp_tvalid)
      else $error("clear transfer did not produce a result");
   a_record_read: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_RECORD)) |=> (state_ff == ST_READ))
      else $error("record transfer did not start a ring read");
`endif

endmodule
